FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/srs_pkg.sv
// types, constants and helpers for the selective repeat sender
// no dependencies
package srs_pkg;

  localparam int WINDOW    = 8;
  localparam int SEQ_SPACE = 2 * WINDOW;
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int SEQ_W     = SLOT_W + 1;

  // fixed field widths of the transaction ports
  localparam int MODE_W    = 2;
  localparam int ACK_W     = 4;
  localparam int STATUS_W  = 3;
  localparam int SEQ_NUM_W = 4;
  localparam int SLOT_NUM_W = 3;
  localparam int CNT_W     = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEW     = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SENT     = 3'd0,
    ST_FULL     = 3'd1,
    ST_ACK_TOOK = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_RESEND   = 3'd4,
    ST_NOTHING  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLIDE,
    S_RESEND
  } state_t;

  // distance from one sequence number to another, modulo the sequence space
  function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] from,
                                                input logic [SEQ_W-1:0] to);
    seq_dist = to - from;
  endfunction

endpackage

FILE: rtl/core/selective_repeat_sender.sv
// selective repeat arq sender: window bookkeeping, ack slide and timeout resend
// depends on srs_pkg and assert_macros.svh
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+--------------------------------
//  event    | in_mode, in_ack_number              | start high while busy low
//  result   | out_status ... out_last             | out_valid strobe, one cycle each
//
// new message, ignored ack, unused mode or empty timeout: one transaction, result
//   registered in the cycle after accept, block ready again at once
// accepted ack: S_SLIDE moves the base over each acknowledged oldest slot in turn, then gives the result
// timeout: S_RESEND walks the slot indices, up to WINDOW of them, with up to WINDOW
//   results; the single slot index counter idx_r scans the window
// rst_n is synchronous; reset empties the window with base and next at zero
// the receiver cannot stall, results go out the cycle they are ready
module selective_repeat_sender (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [srs_pkg::MODE_W-1:0]      in_mode,
  input  logic [srs_pkg::ACK_W-1:0]       in_ack_number,
  output logic                            out_valid,
  output logic [srs_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_send_valid,
  output logic [srs_pkg::SEQ_NUM_W-1:0]   out_seq_number,
  output logic [srs_pkg::SLOT_NUM_W-1:0]  out_buffer_slot,
  output logic                            out_restart_timer,
  output logic [srs_pkg::SEQ_NUM_W-1:0]   out_window_base,
  output logic [srs_pkg::CNT_W-1:0]       out_in_flight,
  output logic                            out_last
);
  import srs_pkg::*;
  `include "assert_macros.svh"

  // sequencer and window state
  state_t              state_r, state_nxt;
  logic [SEQ_W-1:0]    base_r, base_nxt;
  logic [SEQ_W-1:0]    next_r, next_nxt;
  logic [WINDOW-1:0]   acked_r, acked_nxt;
  logic [WINDOW-1:0]   outst_r, outst_nxt;
  // snapshot of slots still to resend during a timeout walk
  logic [WINDOW-1:0]   pend_r, pend_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;

  // sequence number held by each slot, only read for outstanding slots
  logic [SEQ_W-1:0]    seq_mem_r [WINDOW];
  logic                seq_we;

  // result register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_send_r, out_send_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_restart_r, out_restart_nxt;
  logic [SEQ_W-1:0]    out_base_r, out_base_nxt;
  logic [SEQ_W-1:0]    out_flight_r, out_flight_nxt;
  logic                out_last_r, out_last_nxt;

  // shared decode
  logic                accept;
  logic [SEQ_W-1:0]    ack_seq;
  logic [SEQ_W-1:0]    flight_now;
  logic                window_room;
  logic                ack_ok;
  logic [WINDOW-1:0]   pend_now;
  logic                slide_go;
  logic [WINDOW-1:0]   pend_rest;
  logic                resend_last;

  assign accept      = start && (state_r == S_IDLE);
  assign ack_seq     = SEQ_W'(in_ack_number);
  assign flight_now  = seq_dist(base_r, next_r);
  assign window_room = (int'(flight_now) < WINDOW);
  // ack must lie in the sequence space and inside [base, next)
  assign ack_ok      = (int'(in_ack_number) < SEQ_SPACE) &&
                       (seq_dist(base_r, ack_seq) < flight_now);
  assign pend_now    = outst_r & ~acked_r;
  // base slides while the oldest slot is acknowledged
  assign slide_go    = (base_r != next_r) && acked_r[base_r[SLOT_W-1:0]];
  // pending slots left once the current index is served
  assign pend_rest   = pend_r & ~(WINDOW'(1) << idx_r);
  assign resend_last = (pend_rest == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_mode == MODE_ACK) && ack_ok) begin
            state_nxt = S_SLIDE;
          end else if ((in_mode == MODE_TIMEOUT) && (pend_now != '0)) begin
            state_nxt = S_RESEND;
          end
        end
      end
      S_SLIDE: begin
        if (!slide_go) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESEND: begin
        if (pend_r[idx_r] && resend_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    base_nxt        = base_r;
    next_nxt        = next_r;
    acked_nxt       = acked_r;
    outst_nxt       = outst_r;
    pend_nxt        = pend_r;
    idx_nxt         = idx_r;
    seq_we          = 1'b0;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = ST_IGNORED;
    out_send_nxt    = 1'b0;
    out_seq_nxt     = '0;
    out_slot_nxt    = '0;
    out_restart_nxt = 1'b0;
    out_base_nxt    = base_r;
    out_flight_nxt  = flight_now;
    out_last_nxt    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_NEW: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (window_room) begin
                // next sequence number goes out and its slot becomes outstanding
                seq_we                     = 1'b1;
                acked_nxt[next_r[SLOT_W-1:0]] = 1'b0;
                outst_nxt[next_r[SLOT_W-1:0]] = 1'b1;
                next_nxt                   = next_r + SEQ_W'(1);
                out_status_nxt             = ST_SENT;
                out_send_nxt               = 1'b1;
                out_seq_nxt                = next_r;
                out_slot_nxt               = next_r[SLOT_W-1:0];
                out_restart_nxt            = 1'b1;
                out_flight_nxt             = seq_dist(base_r, next_r + SEQ_W'(1));
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            MODE_ACK: begin
              if (ack_ok) begin
                // result follows once the base has slid
                acked_nxt[ack_seq[SLOT_W-1:0]] = 1'b1;
              end else begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_IGNORED;
              end
            end
            MODE_TIMEOUT: begin
              if (pend_now != '0) begin
                pend_nxt = pend_now;
                idx_nxt  = '0;
              end else begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_NOTHING;
              end
            end
            default: begin
              // unused event code
              out_valid_nxt  = 1'b1;
              out_last_nxt   = 1'b1;
              out_status_nxt = ST_IGNORED;
            end
          endcase
        end
      end
      S_SLIDE: begin
        if (slide_go) begin
          acked_nxt[base_r[SLOT_W-1:0]] = 1'b0;
          outst_nxt[base_r[SLOT_W-1:0]] = 1'b0;
          base_nxt                      = base_r + SEQ_W'(1);
        end else begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_ACK_TOOK;
        end
      end
      S_RESEND: begin
        idx_nxt = idx_r + SLOT_W'(1);
        if (pend_r[idx_r]) begin
          pend_nxt        = pend_rest;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_RESEND;
          out_send_nxt    = 1'b1;
          out_seq_nxt     = seq_mem_r[idx_r];
          out_slot_nxt    = idx_r;
          out_restart_nxt = 1'b1;
          out_last_nxt    = resend_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      acked_r     <= '0;
      outst_r     <= '0;
      pend_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      acked_r     <= acked_nxt;
      outst_r     <= outst_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_send_r    <= out_send_nxt;
    out_seq_r     <= out_seq_nxt;
    out_slot_r    <= out_slot_nxt;
    out_restart_r <= out_restart_nxt;
    out_base_r    <= out_base_nxt;
    out_flight_r  <= out_flight_nxt;
    out_last_r    <= out_last_nxt;
    if (seq_we) begin
      seq_mem_r[next_r[SLOT_W-1:0]] <= next_r;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_send_valid    = out_send_r;
  assign out_seq_number    = SEQ_NUM_W'(out_seq_r);
  assign out_buffer_slot   = SLOT_NUM_W'(out_slot_r);
  assign out_restart_timer = out_restart_r;
  assign out_window_base   = SEQ_NUM_W'(out_base_r);
  assign out_in_flight     = CNT_W'(out_flight_r);
  assign out_last          = out_last_r;

  // a timeout walk always has something left to resend
  `ASSERT_SAME(a_resend_pending, state_r == S_RESEND, pend_r != '0, "resend walk with empty set")
  // the window never holds more than WINDOW sequence numbers
  `ASSERT_ALWAYS(a_window_bound, int'(flight_now) <= WINDOW, "window overfilled")
  // a new message transaction gives its single result in the next cycle
  `ASSERT_NEXT(a_new_result, accept && (in_mode == MODE_NEW), out_valid && out_last, "new message result missing")
  // a sent packet sits in the slot of its sequence number
  `ASSERT_SAME(a_slot_match, out_valid && out_send_valid, out_buffer_slot == out_seq_number[SLOT_W-1:0], "slot does not match sequence")

endmodule
